/* sv/pab_pkg.sv */
// Shared types and constants for the proximity alarm blinker.
// No dependencies; every other file in the block imports this package.

package pab_pkg;

	// Item codes carried in the mode field
	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_ON   = 2'd1,
		MODE_OFF  = 2'd2,
		MODE_TEST = 2'd3
	} mode_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLOUR_A   = 3'd0,
		REG_COLOUR_B   = 3'd1,
		REG_BLINK      = 3'd2,
		REG_TRIGGER    = 3'd3,
		REG_HOLD       = 3'd4
	} reg_idx_t;

	localparam logic [23:0] COLOUR_A_RST = 24'hFF0000;
	localparam logic [23:0] COLOUR_B_RST = 24'h0000FF;
	localparam logic [31:0] BLINK_RST    = 32'd250;
	localparam logic [15:0] TRIGGER_RST  = 16'd0;
	localparam logic [31:0] HOLD_RST     = 32'd0;

	localparam logic [31:0] TEST_MS    = 32'd3000;
	localparam logic [7:0]  FULL_LEVEL = 8'd255;

	typedef struct packed {
		logic [23:0] colour_a;
		logic [23:0] colour_b;
		logic [31:0] blink_period_ms;
		logic [15:0] trigger_distance_mm;
		logic [31:0] hold_timeout_ms;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] now_ms;
		logic [15:0] distance_mm;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       buzzer;
	} drive_t;

	typedef struct packed {
		drive_t drive;
		logic   alarm_on;
		logic   testing;
	} res_t;

	localparam drive_t DRIVE_OFF = '{red: 8'd0, green: 8'd0, blue: 8'd0, buzzer: 1'b0};

endpackage

/* sv/pab_ifs.sv */
// Valid/ready channel interfaces for item and result beats.
// Depends on pab_pkg for the payload types.

interface pab_item_if import pab_pkg::*; ();
	logic        valid;
	logic        ready;
	mode_t       mode;
	logic [31:0] now_ms;
	logic [15:0] distance_mm;

	modport source (output valid, mode, now_ms, distance_mm, input ready);
	modport sink (input valid, mode, now_ms, distance_mm, output ready);
endinterface

interface pab_result_if ();
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       buzzer;
	logic       alarm_on;
	logic       testing;

	modport source (output valid, red, green, blue, buzzer, alarm_on, testing, input ready);
	modport sink (input valid, red, green, blue, buzzer, alarm_on, testing, output ready);
endinterface

/* sv/proximity_alarm_blinker.sv */
// Proximity alarm blinker top level: input stage, control, result register.
// Depends on pab_pkg, pab_ifs, pab_cfg_regs and pab_ctrl.
//
//   channel   direction  beat
//   item      in         mode, now_ms, distance_mm
//   result    out        red, green, blue, buzzer, alarm_on, testing
//   cfg_*     in         cfg_index, cfg_wdata on cfg_we (no handshake)
//
// One item per cycle sustained while the result side accepts; an accepted item
// passes through the input register, then the result register, before its
// result beat is valid.
// The state update and the result are computed combinationally while an item
// sits in the input register, and committed as it moves to the result register.
// arst_n clears both stage valids, control state and config; data registers have no reset.
// A stalled result holds the result register and then the input register.

module proximity_alarm_blinker import pab_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	pab_item_if.sink              item,
	pab_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1, res_valid_q, res_free, advance;
	res_t  res_n, res_q;

	pab_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Move a beat on when the result register is empty or being drained
	assign res_free   = !res_valid_q || result.ready;
	assign advance    = valid_s1 && res_free;
	assign item.ready = !valid_s1 || res_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= '{mode: item.mode, now_ms: item.now_ms, distance_mm: item.distance_mm};
		end
	end

	pab_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res_n)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign result.valid    = res_valid_q;
	assign result.red      = res_q.drive.red;
	assign result.green    = res_q.drive.green;
	assign result.blue     = res_q.drive.blue;
	assign result.buzzer   = res_q.drive.buzzer;
	assign result.alarm_on = res_q.alarm_on;
	assign result.testing  = res_q.testing;

endmodule

/* sv/pab_cfg_regs.sv */
// Configuration register file for the proximity alarm blinker.
// Depends on pab_pkg for the register indexes and reset values.

module pab_cfg_regs import pab_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Decode the index and load the addressed register; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.colour_a            <= COLOUR_A_RST;
			cfg_q.colour_b            <= COLOUR_B_RST;
			cfg_q.blink_period_ms     <= BLINK_RST;
			cfg_q.trigger_distance_mm <= TRIGGER_RST;
			cfg_q.hold_timeout_ms     <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_COLOUR_A: cfg_q.colour_a            <= cfg_wdata[23:0];
				REG_COLOUR_B: cfg_q.colour_b            <= cfg_wdata[23:0];
				REG_BLINK:    cfg_q.blink_period_ms     <= cfg_wdata;
				REG_TRIGGER:  cfg_q.trigger_distance_mm <= cfg_wdata[15:0];
				REG_HOLD:     cfg_q.hold_timeout_ms     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/pab_ctrl.sv */
// Alarm state, latched requests, test timer and blink timer, with the
// next-state logic for one item. Depends on pab_pkg.

module pab_ctrl import pab_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  advance,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	logic        alarm_q, test_q, phase_q, pend_on_q, pend_off_q;
	logic [31:0] test_start_q, last_detect_q, last_blink_q;
	drive_t      drive_q;

	logic        alarm_n, test_n, phase_n, pend_on_n, pend_off_n, done;
	logic [31:0] test_start_n, last_detect_n, last_blink_n;
	drive_t      drive_n;

	logic        near, test_over, hold_over, blink_due;
	logic [31:0] detect_base, test_elapsed, detect_elapsed, blink_elapsed;

	// Distance and time comparisons; time differences are modulo 2^32
	assign near           = item.distance_mm <= cfg.trigger_distance_mm;
	assign test_elapsed   = item.now_ms - test_start_q;
	assign test_over      = test_elapsed >= TEST_MS;
	assign detect_base    = pend_on_q ? item.now_ms : last_detect_q;
	assign detect_elapsed = item.now_ms - detect_base;
	assign hold_over      = detect_elapsed >= cfg.hold_timeout_ms;
	assign blink_elapsed  = item.now_ms - last_blink_q;
	assign blink_due      = blink_elapsed >= cfg.blink_period_ms;

	// Work out the state after this item
	always_comb begin
		alarm_n       = alarm_q;
		test_n        = test_q;
		phase_n       = phase_q;
		pend_on_n     = pend_on_q;
		pend_off_n    = pend_off_q;
		test_start_n  = test_start_q;
		last_detect_n = last_detect_q;
		last_blink_n  = last_blink_q;
		drive_n       = drive_q;
		done          = 1'b0;
		unique case (item.mode)
			MODE_TICK: begin
				if (test_q) begin
					// only the test end matters while a test runs
					if (test_over) begin
						drive_n = DRIVE_OFF;
						test_n  = 1'b0;
						alarm_n = 1'b0;
					end
				end else begin
					// serve latched requests, on before off
					if (pend_on_q) begin
						alarm_n       = 1'b1;
						last_detect_n = item.now_ms;
						pend_on_n     = 1'b0;
					end else if (pend_off_q) begin
						alarm_n    = 1'b0;
						drive_n    = DRIVE_OFF;
						pend_off_n = 1'b0;
						done       = 1'b1;
					end
					if (!done) begin
						if (!alarm_n && near) begin
							alarm_n       = 1'b1;
							last_detect_n = item.now_ms;
						end else if (alarm_n) begin
							if (!near && hold_over) begin
								alarm_n = 1'b0;
								drive_n = DRIVE_OFF;
							end else begin
								if (near) begin
									last_detect_n = item.now_ms;
								end
								// alternate colours once the period has gone by
								if (blink_due) begin
									phase_n      = !phase_q;
									last_blink_n = item.now_ms;
									drive_n      = phase_n
										? drive_t'{red: cfg.colour_a[23:16],
											green: cfg.colour_a[15:8],
											blue: cfg.colour_a[7:0], buzzer: 1'b1}
										: drive_t'{red: cfg.colour_b[23:16],
											green: cfg.colour_b[15:8],
											blue: cfg.colour_b[7:0], buzzer: 1'b1};
								end
							end
						end
					end
				end
			end
			MODE_ON:  pend_on_n = 1'b1;
			MODE_OFF: pend_off_n = 1'b1;
			MODE_TEST: begin
				test_n       = 1'b1;
				test_start_n = item.now_ms;
				drive_n      = '{red: FULL_LEVEL, green: 8'd0, blue: 8'd0, buzzer: 1'b1};
			end
			default: ;
		endcase
	end

	// Commit the new state when the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q       <= 1'b0;
			test_q        <= 1'b0;
			phase_q       <= 1'b0;
			pend_on_q     <= 1'b0;
			pend_off_q    <= 1'b0;
			test_start_q  <= '0;
			last_detect_q <= '0;
			last_blink_q  <= '0;
			drive_q       <= DRIVE_OFF;
		end else if (advance) begin
			alarm_q       <= alarm_n;
			test_q        <= test_n;
			phase_q       <= phase_n;
			pend_on_q     <= pend_on_n;
			pend_off_q    <= pend_off_n;
			test_start_q  <= test_start_n;
			last_detect_q <= last_detect_n;
			last_blink_q  <= last_blink_n;
			drive_q       <= drive_n;
		end
	end

	assign res = '{drive: drive_n, alarm_on: alarm_n, testing: test_n};

endmodule

/* bench/tb_proximity_alarm_blinker.sv */
// Self-checking testbench for proximity_alarm_blinker: directed and random item beats.
// Depends on pab_pkg, pab_ifs and the block's RTL; the alarm behavior is predicted in-bench.
`timescale 1ns / 1ps

module tb_proximity_alarm_blinker;
	import pab_pkg::*;

	localparam int MAX_PAUSE = 13;
	localparam int LATENCY_PAD = 4;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PHASES = 7;
	localparam int ITEMS_PER_PHASE = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pab_item_if item_ch ();
	pab_result_if result_ch ();

	proximity_alarm_blinker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Predicted alarm state, starting from reset values
	cfg_t alarm_cfg = '{colour_a: COLOUR_A_RST, colour_b: COLOUR_B_RST,
		blink_period_ms: BLINK_RST, trigger_distance_mm: TRIGGER_RST,
		hold_timeout_ms: HOLD_RST};
	logic alarm = 1'b0;
	logic in_test = 1'b0;
	logic [31:0] test_t0 = '0;
	logic [31:0] detect_t = '0;
	logic [31:0] blink_t = '0;
	logic blink_phase = 1'b0;
	logic on_latched = 1'b0;
	logic off_latched = 1'b0;
	drive_t lamp = DRIVE_OFF;

	res_t predicted_outputs[$];
	int errors = 0;
	int cycle_count = 0;
	logic no_idle = 1'b0;

	// Clock: 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int pause_draw();
		return no_idle ? 0 : $urandom_range(0, MAX_PAUSE);
	endfunction

	// Advance the alarm machine on a tick
	task automatic tick_alarm(input logic [31:0] now, input logic [15:0] dist_mm);
		logic [23:0] colour;
		if (in_test) begin
			if (now - test_t0 >= TEST_MS) begin
				lamp = DRIVE_OFF;
				in_test = 1'b0;
				alarm = 1'b0;
			end
			return;
		end
		// Serve latched requests, on first
		if (on_latched) begin
			alarm = 1'b1;
			detect_t = now;
			on_latched = 1'b0;
		end else if (off_latched) begin
			alarm = 1'b0;
			lamp = DRIVE_OFF;
			off_latched = 1'b0;
			return;
		end
		if (!alarm && dist_mm <= alarm_cfg.trigger_distance_mm) begin
			alarm = 1'b1;
			detect_t = now;
		end else if (alarm) begin
			if (dist_mm > alarm_cfg.trigger_distance_mm) begin
				if (now - detect_t >= alarm_cfg.hold_timeout_ms) begin
					alarm = 1'b0;
					lamp = DRIVE_OFF;
					return;
				end
			end else begin
				detect_t = now;
			end
			// Alternate colours once the blink period has run out
			if (now - blink_t >= alarm_cfg.blink_period_ms) begin
				blink_phase = !blink_phase;
				colour = blink_phase ? alarm_cfg.colour_a : alarm_cfg.colour_b;
				lamp = '{red: colour[23:16], green: colour[15:8], blue: colour[7:0],
					buzzer: 1'b1};
				blink_t = now;
			end
		end
	endtask

	// Apply one accepted item and queue the outputs it leaves behind
	task automatic step_alarm(input mode_t md, input logic [31:0] now,
		input logic [15:0] dist_mm);
		res_t r;
		case (md)
		MODE_TICK: tick_alarm(now, dist_mm);
		MODE_ON: on_latched = 1'b1;
		MODE_OFF: off_latched = 1'b1;
		default: begin
			in_test = 1'b1;
			test_t0 = now;
			lamp = '{red: FULL_LEVEL, green: 8'd0, blue: 8'd0, buzzer: 1'b1};
		end
		endcase
		r.drive = lamp;
		r.alarm_on = alarm;
		r.testing = in_test;
		predicted_outputs.push_back(r);
	endtask

	// Send one item beat after a random gap, predict on accept
	task automatic send_item(input mode_t md, input logic [31:0] now,
		input logic [15:0] dist_mm);
		int gap;
		gap = pause_draw();
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode <= md;
		item_ch.now_ms <= now;
		item_ch.distance_mm <= dist_mm;
		@(posedge clk);
		while (item_ch.ready !== 1'b1) @(posedge clk);
		step_alarm(md, now, dist_mm);
	endtask

	// Hold off until every predicted beat has come out, then let the pipe drain
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (predicted_outputs.size() != 0) @(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	// Write all registers while idle; upper bits of narrow registers carry junk
	task automatic load_config(input cfg_t c);
		reg_idx_t idx;
		logic [CFG_DATA_W-1:0] data;
		settle();
		idx = idx.first();
		repeat (idx.num()) begin
			case (idx)
			REG_COLOUR_A: data = {8'($urandom()), c.colour_a};
			REG_COLOUR_B: data = {8'($urandom()), c.colour_b};
			REG_BLINK: data = c.blink_period_ms;
			REG_TRIGGER: data = {16'($urandom()), c.trigger_distance_mm};
			default: data = c.hold_timeout_ms;
			endcase
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_wdata <= data;
			@(posedge clk);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
		alarm_cfg = c;
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Result side: random stalls, check each beat against the oldest prediction
	initial begin
		int stall;
		res_t want;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = pause_draw();
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (result_ch.valid !== 1'b1) @(posedge clk);
			if (predicted_outputs.size() == 0) begin
				$display("%0t: result beat expected none, actual %0h %0h %0h %0b %0b %0b",
					$time, result_ch.red, result_ch.green, result_ch.blue,
					result_ch.buzzer, result_ch.alarm_on, result_ch.testing);
				errors++;
			end else begin
				want = predicted_outputs.pop_front();
				compare_field("red", want.drive.red, result_ch.red);
				compare_field("green", want.drive.green, result_ch.green);
				compare_field("blue", want.drive.blue, result_ch.blue);
				compare_field("buzzer", 8'(want.drive.buzzer), 8'(result_ch.buzzer));
				compare_field("alarm_on", 8'(want.alarm_on), 8'(result_ch.alarm_on));
				compare_field("testing", 8'(want.testing), 8'(result_ch.testing));
			end
		end
	end

	// Reset registers: trigger on zero distance, first blink, zero hold timeout
	task automatic test_reset_defaults();
		send_item(MODE_TICK, 32'd100, 16'd0);
		send_item(MODE_TICK, 32'd400, 16'd0);
		send_item(MODE_TICK, 32'd500, 16'd1);
	endtask

	// Latched requests, test start, restart, wrap of test time, test end
	task automatic test_commands();
		send_item(MODE_ON, 32'd900, 16'hFFFF);
		send_item(MODE_OFF, 32'd905, 16'h0000);
		// on served first, off left pending
		send_item(MODE_TICK, 32'd1000, 16'hFFFF);
		send_item(MODE_TICK, 32'd1010, 16'h0000);
		send_item(MODE_TEST, 32'hFFFF_F800, 16'h0000);
		send_item(MODE_ON, 32'hFFFF_F900, 16'h1234);
		send_item(MODE_TICK, 32'hFFFF_FFFF, 16'h0000);
		send_item(MODE_TEST, 32'h0000_0100, 16'hFFFF);
		send_item(MODE_TICK, 32'h0000_0100 + 32'd2999, 16'h0000);
		send_item(MODE_TICK, 32'h0000_0100 + 32'd3000, 16'h0000);
		// pending on served, blink check on the same tick
		send_item(MODE_TICK, 32'h0000_0100 + 32'd3001, 16'h0000);
	endtask

	// Register extremes: zero and full-scale periods, triggers and colours
	task automatic test_extreme_config();
		load_config('{colour_a: 24'hFFFFFF, colour_b: 24'h000000, blink_period_ms: 32'd0,
			trigger_distance_mm: 16'hFFFF, hold_timeout_ms: 32'hFFFF_FFFF});
		send_item(MODE_TICK, 32'd5000, 16'hFFFF);
		send_item(MODE_TICK, 32'd5000, 16'hFFFF);
		send_item(MODE_TICK, 32'd5001, 16'h0000);
		load_config('{colour_a: 24'h123456, colour_b: 24'hA5C3E1,
			blink_period_ms: 32'hFFFF_FFFF, trigger_distance_mm: 16'h0000,
			hold_timeout_ms: 32'd0});
		send_item(MODE_TICK, 32'd6000, 16'd1);
		send_item(MODE_TICK, 32'd6001, 16'd0);
		// elapsed time wraps to the full-scale period
		send_item(MODE_TICK, 32'd5000, 16'd0);
	endtask

	// Random phases: mostly ticks near the trigger with advancing time, some commands
	task automatic test_random_traffic();
		cfg_t c;
		logic [31:0] clock_ms;
		int trig;
		int dist_mm;
		int pick;
		for (int phase_n = 0; phase_n < RANDOM_PHASES; phase_n++) begin
			c.colour_a = 24'($urandom());
			c.colour_b = 24'($urandom());
			case ($urandom_range(0, 5))
			0: c.blink_period_ms = 32'd0;
			1: c.blink_period_ms = 32'hFFFF_FFFF;
			default: c.blink_period_ms = $urandom_range(1, 150);
			endcase
			case ($urandom_range(0, 4))
			0: c.trigger_distance_mm = 16'h0000;
			1: c.trigger_distance_mm = 16'hFFFF;
			default: c.trigger_distance_mm = 16'($urandom_range(1, 65534));
			endcase
			case ($urandom_range(0, 4))
			0: c.hold_timeout_ms = 32'd0;
			1: c.hold_timeout_ms = 32'hFFFF_FFFF;
			default: c.hold_timeout_ms = $urandom_range(1, 400);
			endcase
			load_config(c);
			no_idle = (phase_n % 3 == 1);
			trig = int'(c.trigger_distance_mm);
			clock_ms = (phase_n == 2) ? 32'hFFFF_FF00 : $urandom();
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// drain once mid-phase
				if (phase_n == 3 && n == ITEMS_PER_PHASE / 2)
					settle();
				pick = $urandom_range(0, 199);
				if (pick < 160) begin
					if ($urandom_range(0, 49) == 0)
						clock_ms = clock_ms + 32'($urandom_range(0, 6000));
					else
						clock_ms = clock_ms + 32'($urandom_range(0, 60));
					case ($urandom_range(0, 9))
					0: dist_mm = $urandom_range(0, 65535);
					1, 2, 3, 4, 5: dist_mm = trig -
						int'($urandom_range(0, (trig < 40) ? trig : 40));
					default: dist_mm = (trig + 40 > 65535) ? 65535 :
						trig + int'($urandom_range(1, 40));
					endcase
					send_item(MODE_TICK, clock_ms, 16'(dist_mm));
				end else if (pick < 172) begin
					send_item(MODE_ON, clock_ms, 16'($urandom()));
				end else if (pick < 184) begin
					send_item(MODE_OFF, clock_ms, 16'($urandom()));
				end else if (pick < 188) begin
					send_item(MODE_TEST, clock_ms, 16'($urandom()));
				end else begin
					send_item(mode_t'($urandom_range(0, 3)), $urandom(), 16'($urandom()));
				end
			end
		end
		no_idle = 1'b0;
	endtask

	// Main sequence
	initial begin
		item_ch.valid <= 1'b0;
		item_ch.mode <= MODE_TICK;
		item_ch.now_ms <= '0;
		item_ch.distance_mm <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_COLOUR_A;
		cfg_wdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_commands();
		test_extreme_config();
		test_random_traffic();
		settle();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
